// ===== rtl/core/fwsc_pkg.sv =====
// Shared constants, tables and types of the four-wheel steering command block.
package fwsc_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned VELOCITY_BITS_DEF = 16;

  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned Z_W        = 26;
  localparam int unsigned STEER_W    = 15;
  localparam int unsigned WHEEL_W    = 18;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TANK_W     = 14;
  localparam int unsigned INVK_W     = 30;
  localparam int unsigned OUT_TDATA_W = 136;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_STEER_ANGLE = 2'd1;

  localparam logic [GAIN_W-1:0] ROTATION_GAIN_RST    = 16'd11314;
  localparam logic [TANK_W-1:0] TANK_STEER_ANGLE_RST = 14'd6434;

  localparam logic signed [STEER_W-1:0] ANGLE_MAX = 15'sd12868;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = 18'sd131071;

  // 1/K in Q.30 before the stage dependent correction
  localparam longint unsigned INVK_BASE = 64'd652032874;
  localparam longint unsigned INVK_CORR = 64'd434688583;

  // atan(2^-i) in Q.24
  localparam logic [23:0] ATAN_Q24 [24] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  // Per-command flags that ride along with the CORDIC data
  typedef struct packed {
    logic                        rot;
    logic                        x_neg;
    logic                        x_zero;
    logic                        y_pos;
    logic                        vec_zero;
    logic signed [WHEEL_W-1:0]   spd_rot;
  } side_t;

endpackage

// ===== rtl/core/four_wheel_steer_command.sv =====
// Top level of the four-wheel steering command block.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | tdata: vel_forward, vel_side, turn_rate
//  m_axis    | out       | tdata: four steer angles, four wheel speeds; tuser: rotate_mode
//  cfg       | in        | cfg_index_i selects the register, cfg_data_i its value
//
// One command per cycle while m_axis is not stalled; the stages are the input register,
// one cell per CORDIC iteration, the scaling stage and the output register.
// Each stage has its own valid bit, so bubbles collapse and the input keeps
// flowing while a finished result waits at the output, until the pipeline is full.
// Reset empties the pipeline and loads the register defaults; cfg is always ready.
module four_wheel_steer_command #(
  parameter int unsigned CORDIC_STAGES = fwsc_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned VELOCITY_BITS = fwsc_pkg::VELOCITY_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // vel_forward, vel_side, turn_rate (low to high), zero filled to bytes
  input  logic [((3*VELOCITY_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // steer_left_front, steer_left_rear, steer_right_rear, steer_right_front,
  // wheel_left_front, wheel_left_rear, wheel_right_front, wheel_right_rear, zero fill
  output logic [fwsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // rotate_mode
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fwsc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fwsc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DATA_W = VELOCITY_BITS + fwsc_pkg::GUARD_BITS + 3;

  logic [fwsc_pkg::GAIN_W-1:0]       gain_q, gain_d;
  logic [fwsc_pkg::TANK_W-1:0]       tank_q, tank_d;
  logic                              cfg_wr;

  logic                              v_c [CORDIC_STAGES+1];
  logic                              r_c [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0]          cx_c [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0]          cy_c [CORDIC_STAGES+1];
  logic signed [fwsc_pkg::Z_W-1:0]   z_c  [CORDIC_STAGES+1];
  fwsc_pkg::side_t                   side_c [CORDIC_STAGES+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    gain_d = gain_q;
    tank_d = tank_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        fwsc_pkg::REG_ROTATION_GAIN:    gain_d = cfg_data_i;
        fwsc_pkg::REG_TANK_STEER_ANGLE: tank_d = cfg_data_i[fwsc_pkg::TANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= fwsc_pkg::ROTATION_GAIN_RST;
      tank_q <= fwsc_pkg::TANK_STEER_ANGLE_RST;
    end else begin
      gain_q <= gain_d;
      tank_q <= tank_d;
    end
  end

  fwsc_front #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .DATA_W        (DATA_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .vel_forward_i ($signed(s_axis_tdata[VELOCITY_BITS-1:0])),
    .vel_side_i    ($signed(s_axis_tdata[2*VELOCITY_BITS-1:VELOCITY_BITS])),
    .turn_rate_i   ($signed(s_axis_tdata[3*VELOCITY_BITS-1:2*VELOCITY_BITS])),
    .gain_i        (gain_q),
    .valid_o       (v_c[0]),
    .ready_i       (r_c[0]),
    .cx_o          (cx_c[0]),
    .cy_o          (cy_c[0]),
    .side_o        (side_c[0])
  );

  assign z_c[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    fwsc_cell #(
      .DATA_W (DATA_W),
      .STAGE  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_c[i]),
      .ready_o (r_c[i]),
      .cx_i    (cx_c[i]),
      .cy_i    (cy_c[i]),
      .z_i     (z_c[i]),
      .side_i  (side_c[i]),
      .valid_o (v_c[i+1]),
      .ready_i (r_c[i+1]),
      .cx_o    (cx_c[i+1]),
      .cy_o    (cy_c[i+1]),
      .z_o     (z_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  fwsc_back #(
    .DATA_W        (DATA_W),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_c[CORDIC_STAGES]),
    .ready_o (r_c[CORDIC_STAGES]),
    .cx_i    (cx_c[CORDIC_STAGES]),
    .z_i     (z_c[CORDIC_STAGES]),
    .side_i  (side_c[CORDIC_STAGES]),
    .tank_i  (tank_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tdata_o (m_axis_tdata),
    .tuser_o (m_axis_tuser)
  );

endmodule

// ===== rtl/core/fwsc_front.sv =====
// Input stage: operand conditioning for the CORDIC and the turn rate product.
module fwsc_front #(
  parameter int unsigned VELOCITY_BITS = fwsc_pkg::VELOCITY_BITS_DEF,
  parameter int unsigned DATA_W        = VELOCITY_BITS + fwsc_pkg::GUARD_BITS + 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [VELOCITY_BITS-1:0]      vel_forward_i,
  input  logic signed [VELOCITY_BITS-1:0]      vel_side_i,
  input  logic signed [VELOCITY_BITS-1:0]      turn_rate_i,
  input  logic [fwsc_pkg::GAIN_W-1:0]          gain_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [DATA_W-1:0]             cx_o,
  output logic signed [DATA_W-1:0]             cy_o,
  output fwsc_pkg::side_t                      side_o
);

  localparam int unsigned PROD_W = VELOCITY_BITS + fwsc_pkg::GAIN_W + 1;

  logic                      v_q, v_d;
  logic                      load;
  logic signed [DATA_W-1:0]  xe, ye, cx_d, cy_d, cx_q, cy_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q, rnd_sum, rnd_shr;
  logic                      rot_d, rot_q, xneg_d, xneg_q, xzero_d, xzero_q;
  logic                      ypos_d, ypos_q, vzero_d, vzero_q;
  logic signed [fwsc_pkg::WHEEL_W-1:0] spd;

  assign ready_o = ~v_q | ready_i;
  assign load    = valid_i & ready_o;
  assign v_d     = ready_o ? valid_i : v_q;

  always_comb begin
    xe      = DATA_W'(vel_forward_i);
    ye      = DATA_W'(vel_side_i);
    xneg_d  = vel_forward_i[VELOCITY_BITS-1];
    cx_d    = (xneg_d ? -xe : xe) <<< fwsc_pkg::GUARD_BITS;
    cy_d    = (xneg_d ? -ye : ye) <<< fwsc_pkg::GUARD_BITS;
    xzero_d = (vel_forward_i == '0);
    ypos_d  = ~vel_side_i[VELOCITY_BITS-1] & (vel_side_i != '0);
    vzero_d = xzero_d & (vel_side_i == '0);
    rot_d   = (turn_rate_i != '0);
    prod_d  = PROD_W'(turn_rate_i) * PROD_W'($signed({1'b0, gain_i}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      prod_q  <= prod_d;
      rot_q   <= rot_d;
      xneg_q  <= xneg_d;
      xzero_q <= xzero_d;
      ypos_q  <= ypos_d;
      vzero_q <= vzero_d;
    end
  end

  // round Q.22 to Q.10, then saturate
  always_comb begin
    rnd_sum = prod_q + PROD_W'(2048);
    rnd_shr = rnd_sum >>> 12;
    if (rnd_shr > PROD_W'(fwsc_pkg::WHEEL_MAX)) begin
      spd = fwsc_pkg::WHEEL_MAX;
    end else if (rnd_shr < -PROD_W'(fwsc_pkg::WHEEL_MAX)) begin
      spd = -fwsc_pkg::WHEEL_MAX;
    end else begin
      spd = rnd_shr[fwsc_pkg::WHEEL_W-1:0];
    end
  end

  assign valid_o         = v_q;
  assign cx_o            = cx_q;
  assign cy_o            = cy_q;
  assign side_o.rot      = rot_q;
  assign side_o.x_neg    = xneg_q;
  assign side_o.x_zero   = xzero_q;
  assign side_o.y_pos    = ypos_q;
  assign side_o.vec_zero = vzero_q;
  assign side_o.spd_rot  = spd;

endmodule

// ===== rtl/core/fwsc_cell.sv =====
// One CORDIC vectoring iteration with its own pipeline register.
module fwsc_cell #(
  parameter int unsigned DATA_W = 27,
  parameter int unsigned STAGE  = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [DATA_W-1:0]           cx_i,
  input  logic signed [DATA_W-1:0]           cy_i,
  input  logic signed [fwsc_pkg::Z_W-1:0]    z_i,
  input  fwsc_pkg::side_t                    side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [DATA_W-1:0]           cx_o,
  output logic signed [DATA_W-1:0]           cy_o,
  output logic signed [fwsc_pkg::Z_W-1:0]    z_o,
  output fwsc_pkg::side_t                    side_o
);

  localparam logic signed [fwsc_pkg::Z_W-1:0] ATAN_I =
    $signed({2'b00, fwsc_pkg::ATAN_Q24[STAGE]});

  logic                              v_q, v_d, load;
  logic signed [DATA_W-1:0]          dx, dy, cx_d, cy_d, cx_q, cy_q;
  logic signed [fwsc_pkg::Z_W-1:0]   z_d, z_q;
  fwsc_pkg::side_t                   side_q;

  assign ready_o = ~v_q | ready_i;
  assign load    = valid_i & ready_o;
  assign v_d     = ready_o ? valid_i : v_q;

  // rotate toward y = 0; y >= 0 takes the negative direction
  always_comb begin
    dx = cy_i >>> STAGE;
    dy = cx_i >>> STAGE;
    if (!cy_i[DATA_W-1]) begin
      cx_d = cx_i + dx;
      cy_d = cy_i - dy;
      z_d  = z_i + ATAN_I;
    end else begin
      cx_d = cx_i - dx;
      cy_d = cy_i + dy;
      z_d  = z_i - ATAN_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/core/fwsc_back.sv =====
// Output stages: gain correction, angle rounding, mode select and result register.
module fwsc_back #(
  parameter int unsigned DATA_W        = 27,
  parameter int unsigned CORDIC_STAGES = fwsc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [DATA_W-1:0]              cx_i,
  input  logic signed [fwsc_pkg::Z_W-1:0]       z_i,
  input  fwsc_pkg::side_t                       side_i,
  input  logic [fwsc_pkg::TANK_W-1:0]           tank_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [fwsc_pkg::OUT_TDATA_W-1:0]      tdata_o,
  output logic                                  tuser_o
);

  localparam int unsigned SHR    = 30 + fwsc_pkg::GUARD_BITS;
  localparam int unsigned MPROD_W = DATA_W - 1 + fwsc_pkg::INVK_W;
  localparam logic [fwsc_pkg::INVK_W-1:0] INVK = fwsc_pkg::INVK_W'(
    fwsc_pkg::INVK_BASE + (fwsc_pkg::INVK_CORR >> (2 * CORDIC_STAGES)));
  localparam int unsigned ZS_W = fwsc_pkg::Z_W + 1;

  logic                                 v1_q, v1_d, v2_q, v2_d, rdy2, load1, load2;
  logic [DATA_W-2:0]                    cx_pos;
  logic [MPROD_W-1:0]                   mprod_d, mprod_q;
  logic signed [ZS_W-1:0]               zs, zsh;
  logic signed [fwsc_pkg::STEER_W-1:0]  ang_d, ang_q, ang_c;
  fwsc_pkg::side_t                      side_q;
  logic [MPROD_W:0]                     msum;
  logic [31:0]                          mag32;
  logic signed [fwsc_pkg::WHEEL_W-1:0]  mag, spd_tr, spd_l, spd_r;
  logic signed [fwsc_pkg::STEER_W-1:0]  tank_a, s_lf, s_lr;
  logic [fwsc_pkg::OUT_TDATA_W-1:0]     tdata_d, tdata_q;
  logic                                 tuser_q;

  assign rdy2    = ~v2_q | ready_i;
  assign ready_o = ~v1_q | rdy2;
  assign load1   = valid_i & ready_o;
  assign load2   = v1_q & rdy2;
  assign v1_d    = ready_o ? valid_i : v1_q;
  assign v2_d    = rdy2 ? v1_q : v2_q;

  // stage 1: magnitude scaling by 1/K, angle rounding to Q2.13
  always_comb begin
    cx_pos  = cx_i[DATA_W-1] ? '0 : cx_i[DATA_W-2:0];
    mprod_d = MPROD_W'(cx_pos) * MPROD_W'(INVK);
    zs      = ZS_W'(z_i) + ZS_W'(1024);
    zsh     = zs >>> 11;
    if (zsh > ZS_W'(fwsc_pkg::ANGLE_MAX)) begin
      ang_c = fwsc_pkg::ANGLE_MAX;
    end else if (zsh < -ZS_W'(fwsc_pkg::ANGLE_MAX)) begin
      ang_c = -fwsc_pkg::ANGLE_MAX;
    end else begin
      ang_c = zsh[fwsc_pkg::STEER_W-1:0];
    end
    priority if (side_i.vec_zero) begin
      ang_d = '0;
    end else if (side_i.x_zero) begin
      ang_d = side_i.y_pos ? fwsc_pkg::ANGLE_MAX : -fwsc_pkg::ANGLE_MAX;
    end else begin
      ang_d = ang_c;
    end
  end

  // stage 2: round magnitude, pick the mode, pack the result
  always_comb begin
    msum  = {1'b0, mprod_q} + ((MPROD_W + 1)'(1) << (SHR - 1));
    mag32 = 32'(msum[MPROD_W:SHR]);
    mag   = (mag32 > 32'(fwsc_pkg::WHEEL_MAX)) ? fwsc_pkg::WHEEL_MAX
                                               : $signed(mag32[fwsc_pkg::WHEEL_W-1:0]);
    if (side_q.vec_zero) begin
      spd_tr = '0;
    end else begin
      spd_tr = side_q.x_neg ? -mag : mag;
    end
    tank_a = (tank_i > fwsc_pkg::TANK_W'(fwsc_pkg::ANGLE_MAX)) ? fwsc_pkg::ANGLE_MAX
                                                               : $signed({1'b0, tank_i});
    if (side_q.rot) begin
      s_lf  = -tank_a;
      s_lr  = tank_a;
      spd_r = side_q.spd_rot;
      spd_l = -side_q.spd_rot;
    end else begin
      s_lf  = ang_q;
      s_lr  = ang_q;
      spd_r = spd_tr;
      spd_l = spd_tr;
    end
    // left front, left rear, right rear, right front steer; lf, lr, rf, rr wheels
    tdata_d = {4'b0000, spd_r, spd_r, spd_l, spd_l, s_lr, s_lf, s_lr, s_lf};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      mprod_q <= mprod_d;
      ang_q   <= ang_d;
      side_q  <= side_i;
    end
    if (load2) begin
      tdata_q <= tdata_d;
      tuser_q <= side_q.rot;
    end
  end

  assign valid_o = v2_q;
  assign tdata_o = tdata_q;
  assign tuser_o = tuser_q;

endmodule

// ===== rtl/core/fwsc_checker.sv =====
// Port-level checks for the steering command block, bound to the top level.
module fwsc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [fwsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser
);

  logic signed [14:0] s_lf, s_lr, s_rr, s_rf;
  logic signed [17:0] w_lf, w_lr, w_rf, w_rr;

  assign s_lf = m_axis_tdata[14:0];
  assign s_lr = m_axis_tdata[29:15];
  assign s_rr = m_axis_tdata[44:30];
  assign s_rf = m_axis_tdata[59:45];
  assign w_lf = m_axis_tdata[77:60];
  assign w_lr = m_axis_tdata[95:78];
  assign w_rf = m_axis_tdata[113:96];
  assign w_rr = m_axis_tdata[131:114];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // rotate mode: alternating angles, left and right wheels opposite
  a_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      s_lf == -s_lr && s_rr == s_lf && s_rf == s_lr &&
      w_lf == w_lr && w_rf == w_rr && w_rf == -w_lf)
    else $error("rotate mode result inconsistent");

  // translation: one angle and one speed for all wheels
  a_trans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      s_lf == s_lr && s_lf == s_rr && s_lf == s_rf &&
      w_lf == w_lr && w_lf == w_rf && w_lf == w_rr)
    else $error("translation result inconsistent");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      s_lf <= fwsc_pkg::ANGLE_MAX && s_lf >= -fwsc_pkg::ANGLE_MAX &&
      w_rf != -18'sd131072)
    else $error("result out of range");

endmodule

bind four_wheel_steer_command fwsc_checker u_fwsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the four-wheel steering command block: directed and random commands vs. a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGES      = fwsc_pkg::CORDIC_STAGES_DEF;
  localparam int unsigned VEL_W       = fwsc_pkg::VELOCITY_BITS_DEF;
  localparam int unsigned IN_TDATA_W  = ((3*VEL_W+7)/8)*8;
  localparam longint      STEER_LIMIT = 12868;
  localparam longint      SPEED_LIMIT = 131071;
  // 1/K of the CORDIC gain in Q.30
  localparam longint unsigned INV_GAIN_Q30 =
    64'd652032874 + (64'd434688583 >> (2*STAGES));
  localparam int unsigned PIPE_DELAY      = STAGES + 3;
  localparam int unsigned HOLD_CYCLES     = 160;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // unused register slots, writes there must be dropped
  localparam logic [fwsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [fwsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  // atan(2^-i), Q.24
  localparam longint ARCTAN_Q24 [16] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  typedef struct packed {
    logic [3:0][fwsc_pkg::WHEEL_W-1:0] wheel;  // lf, lr, rf, rr from index 0
    logic [3:0][fwsc_pkg::STEER_W-1:0] steer;  // lf, lr, rr, rf from index 0
    logic                              rotate_mode;
  } steer_result_t;

  string steer_fields [4] = '{"steer_left_front", "steer_left_rear",
                              "steer_right_rear", "steer_right_front"};
  string wheel_fields [4] = '{"wheel_left_front", "wheel_left_rear",
                              "wheel_right_front", "wheel_right_rear"};

  class steer_scoreboard;
    longint        gain;
    longint        tank_angle;
    steer_result_t pending_steering [$];
    int unsigned   mismatches;

    function new();
      gain       = fwsc_pkg::ROTATION_GAIN_RST;
      tank_angle = fwsc_pkg::TANK_STEER_ANGLE_RST;
      mismatches = 0;
    endfunction

    function void write_register(logic [fwsc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [fwsc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fwsc_pkg::REG_ROTATION_GAIN:    gain = data;
        fwsc_pkg::REG_TANK_STEER_ANGLE: tank_angle = data[fwsc_pkg::TANK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function steer_result_t compute_steering(logic signed [VEL_W-1:0] x,
                                             logic signed [VEL_W-1:0] y,
                                             logic signed [VEL_W-1:0] w);
      steer_result_t r;
      longint xl, yl, wl, cx, cy, z, dx, dy, a, ang, spd;
      longint unsigned mag;
      int i;
      xl = x;
      yl = y;
      wl = w;
      r  = '0;
      if (wl != 0) begin
        a   = (tank_angle > STEER_LIMIT) ? STEER_LIMIT : tank_angle;
        spd = clip((wl * gain + 2048) >>> 12, SPEED_LIMIT);
        r.rotate_mode = 1'b1;
        r.steer[0] = fwsc_pkg::STEER_W'(-a);
        r.steer[1] = fwsc_pkg::STEER_W'(a);
        r.steer[2] = fwsc_pkg::STEER_W'(-a);
        r.steer[3] = fwsc_pkg::STEER_W'(a);
        r.wheel[0] = fwsc_pkg::WHEEL_W'(-spd);
        r.wheel[1] = fwsc_pkg::WHEEL_W'(-spd);
        r.wheel[2] = fwsc_pkg::WHEEL_W'(spd);
        r.wheel[3] = fwsc_pkg::WHEEL_W'(spd);
      end else if (xl != 0 || yl != 0) begin
        // fold into the right half plane, then vector toward y = 0
        cx = ((xl < 0) ? -xl : xl) * 256;
        cy = ((xl < 0) ? -yl : yl) * 256;
        z  = 0;
        for (i = 0; i < STAGES; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            z  += ARCTAN_Q24[i];
          end else begin
            cx -= dx;
            cy += dy;
            z  -= ARCTAN_Q24[i];
          end
        end
        if (xl == 0) ang = (yl > 0) ? STEER_LIMIT : -STEER_LIMIT;
        else ang = clip((z + 1024) >>> 11, STEER_LIMIT);
        if (cx < 0) cx = 0;
        mag = (longint'(cx) * INV_GAIN_Q30 + (64'd1 << 37)) >> 38;
        if (mag > SPEED_LIMIT) mag = SPEED_LIMIT;
        spd = (xl < 0) ? -longint'(mag) : longint'(mag);
        for (i = 0; i < 4; i++) begin
          r.steer[i] = fwsc_pkg::STEER_W'(ang);
          r.wheel[i] = fwsc_pkg::WHEEL_W'(spd);
        end
      end
      return r;
    endfunction

    function void note_command(logic [VEL_W-1:0] x, logic [VEL_W-1:0] y, logic [VEL_W-1:0] w);
      pending_steering = {pending_steering, compute_steering(x, y, w)};
    endfunction

    function void flag(string field, longint exp_val, longint act_val);
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
    endfunction

    function void check_result(logic rot, logic [fwsc_pkg::OUT_TDATA_W-1:0] data);
      steer_result_t got, want;
      int k;
      if (pending_steering.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got tuser %0b tdata %h", $time, rot, data);
        return;
      end
      want = pending_steering.pop_front();
      got.rotate_mode = rot;
      got.steer = data[4*fwsc_pkg::STEER_W-1:0];
      got.wheel = data[4*fwsc_pkg::STEER_W +: 4*fwsc_pkg::WHEEL_W];
      if (got.rotate_mode != want.rotate_mode)
        flag("rotate_mode", want.rotate_mode, got.rotate_mode);
      for (k = 0; k < 4; k++) begin
        if (got.steer[k] != want.steer[k])
          flag(steer_fields[k], $signed(want.steer[k]), $signed(got.steer[k]));
        if (got.wheel[k] != want.wheel[k])
          flag(wheel_fields[k], $signed(want.wheel[k]), $signed(got.wheel[k]));
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [IN_TDATA_W-1:0]               s_axis_tdata = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [fwsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  logic                                m_axis_tuser;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [fwsc_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [fwsc_pkg::CFG_DATA_W-1:0]     cfg_data_i = '0;

  steer_scoreboard board = new();
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  bit          hold_output = 1'b0;
  int unsigned cycle_count = 0;

  four_wheel_steer_command #(
    .CORDIC_STAGES(STAGES),
    .VELOCITY_BITS(VEL_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_command(logic [VEL_W-1:0] x, logic [VEL_W-1:0] y, logic [VEL_W-1:0] w);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({w, y, x});
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(x, y, w);
  endtask

  // stop offering and wait until every pending request has produced its result
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending_steering.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [fwsc_pkg::CFG_IDX_W-1:0] spare,
                                logic [fwsc_pkg::CFG_DATA_W-1:0] gain,
                                logic [fwsc_pkg::CFG_DATA_W-1:0] tank);
    logic [fwsc_pkg::CFG_IDX_W-1:0]  idx [3];
    logic [fwsc_pkg::CFG_DATA_W-1:0] val [3];
    idx = '{spare, fwsc_pkg::REG_ROTATION_GAIN, fwsc_pkg::REG_TANK_STEER_ANGLE};
    val = '{fwsc_pkg::CFG_DATA_W'($urandom), gain, tank};
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_register(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VEL_W-1:0] pick_velocity();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return VEL_W'($urandom_range(0, 128) - 64);
      default: return VEL_W'($urandom);
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    int unsigned stall;
    forever begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [fwsc_pkg::CFG_DATA_W-1:0] gain, tank;
    logic [VEL_W-1:0] w;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed commands at reset register values
    send_command(16'h0000, 16'h0000, 16'h0000);  // zero vector
    send_command(16'h0000, 16'h0001, 16'h0000);  // pure sideways
    send_command(16'h0000, 16'hFFFF, 16'h0000);
    send_command(16'h0000, 16'h7FFF, 16'h0000);
    send_command(16'h0000, 16'h8000, 16'h0000);
    send_command(16'h7FFF, 16'h0000, 16'h0000);
    send_command(16'h8000, 16'h0000, 16'h0000);
    send_command(16'h0001, 16'h0000, 16'h0000);
    send_command(16'hFFFF, 16'h0000, 16'h0000);
    send_command(16'h7FFF, 16'h7FFF, 16'h0000);
    send_command(16'h8000, 16'h8000, 16'h0000);
    send_command(16'h8000, 16'h7FFF, 16'h0000);
    send_command(16'h7FFF, 16'h8000, 16'h0000);
    send_command(16'h0001, 16'hFFFF, 16'h0000);
    send_command(16'hFFFF, 16'h0001, 16'h0000);
    send_command(16'h0400, 16'h0400, 16'h0000);
    send_command(16'hFC00, 16'h0200, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h0001);  // rotate in place
    send_command(16'h0000, 16'h0000, 16'hFFFF);
    send_command(16'h7FFF, 16'h8000, 16'h7FFF);
    send_command(16'h8000, 16'h7FFF, 16'h8000);
    send_command(16'h007B, 16'hFE38, 16'h0002);
    pause_until_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin gain = 16'h0000; tank = 16'd0;     end
        1: begin gain = 16'hFFFF; tank = 16'd12868; end
        2: begin gain = 16'hFFFF; tank = 16'hFFFF;  end  // steer angle above limit
        3: begin gain = 16'd1;    tank = 16'd12869; end
        4: begin gain = 16'd4096; tank = 16'd1;     end
        default: begin
          gain = fwsc_pkg::CFG_DATA_W'($urandom);
          tank = fwsc_pkg::CFG_DATA_W'($urandom_range(0, 16383));
        end
      endcase
      apply_settings(phase[0] ? REG_SPARE_HI : REG_SPARE_LO, gain, tank);
      if (phase == 2) hold_output = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 45 == 0) begin
          in_burst  = ($urandom_range(0, 3) == 0);
          out_burst = ($urandom_range(0, 3) == 0);
        end
        w = ($urandom_range(0, 1) != 0) ? pick_velocity() : 16'h0000;
        send_command(pick_velocity(), pick_velocity(), w);
      end
      pause_until_drained();
    end

    repeat (PIPE_DELAY + 10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_steering.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
